>>> hw/rtl/ctfg_pkg.sv
package ctfg_pkg;

    localparam int ANGLE_W      = 32;
    localparam int TRIG_W       = 16;
    localparam int SEG_CNT_W    = 7;
    localparam int SEG_IDX_W    = 6;
    localparam int MIN_SEGMENTS = 3;
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = 5;

    // CORDIC gain 0.60725293 in Q2.30
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

    // arctan(2^-k) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_q;
        logic signed [TRIG_W-1:0] sin_q;
    } trig_t;

endpackage

>>> hw/rtl/ctfg_cordic.sv
module ctfg_cordic #(
    parameter int ITERATIONS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ctfg_pkg::ANGLE_W-1:0]  phase,
    output logic                          done,
    output ctfg_pkg::trig_t               trig
);
    import ctfg_pkg::*;

    localparam int K_W   = $clog2(ITERATIONS);
    localparam int XY_W  = 34;
    localparam int Z_W   = ANGLE_W + 1;
    localparam int RND_W = XY_W - 15;
    localparam int NEG_W = RND_W + 1;

    localparam logic [1:0] QUAD_EAST  = 2'd0;
    localparam logic [1:0] QUAD_NORTH = 2'd1;
    localparam logic [1:0] QUAD_WEST  = 2'd2;
    localparam logic [1:0] QUAD_SOUTH = 2'd3;

    logic                     running_reg;
    logic                     round_reg;
    logic                     done_reg;
    logic [K_W-1:0]           k_reg;
    logic signed [XY_W-1:0]   x_reg;
    logic signed [XY_W-1:0]   y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic [1:0]               quad_reg;
    trig_t                    trig_reg;

    logic [ANGLE_W-1:0]       phase_bias;
    logic [1:0]               quad_in;
    logic [ANGLE_W-1:0]       rem_in;
    logic signed [XY_W-1:0]   dx;
    logic signed [XY_W-1:0]   dy;
    logic signed [Z_W-1:0]    atan_k;
    logic signed [XY_W-1:0]   x_next;
    logic signed [XY_W-1:0]   y_next;
    logic signed [Z_W-1:0]    z_next;
    logic signed [XY_W-1:0]   x_rnd;
    logic signed [XY_W-1:0]   y_rnd;
    logic signed [RND_W-1:0]  c_rnd;
    logic signed [RND_W-1:0]  s_rnd;
    logic signed [NEG_W-1:0]  c_ext;
    logic signed [NEG_W-1:0]  s_ext;
    logic signed [NEG_W-1:0]  cos_pre;
    logic signed [NEG_W-1:0]  sin_pre;
    trig_t                    trig_next;

    function automatic logic signed [TRIG_W-1:0] sat_trig(input logic signed [NEG_W-1:0] v);
        logic hi_same;
        hi_same = (v[NEG_W-1:TRIG_W-1] == '0) || (v[NEG_W-1:TRIG_W-1] == '1);
        if (hi_same) begin
            return v[TRIG_W-1:0];
        end else if (v[NEG_W-1]) begin
            return {1'b1, {(TRIG_W-1){1'b0}}};
        end else begin
            return {1'b0, {(TRIG_W-1){1'b1}}};
        end
    endfunction

    // split phase into nearest quarter turn and a signed remainder
    assign phase_bias = phase + 32'h2000_0000;
    assign quad_in    = phase_bias[ANGLE_W-1:ANGLE_W-2];
    assign rem_in     = phase - {quad_in, {(ANGLE_W-2){1'b0}}};

    assign dx     = y_reg >>> k_reg;
    assign dy     = x_reg >>> k_reg;
    assign atan_k = {1'b0, ATAN_TURNS[ATAN_IDX_W'(k_reg)]};

    always_comb begin
        if (z_reg[Z_W-1]) begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + atan_k;
        end else begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - atan_k;
        end
    end

    assign x_rnd = x_reg + XY_W'(16384);
    assign y_rnd = y_reg + XY_W'(16384);
    assign c_rnd = x_rnd[XY_W-1:15];
    assign s_rnd = y_rnd[XY_W-1:15];
    assign c_ext = NEG_W'(c_rnd);
    assign s_ext = NEG_W'(s_rnd);

    always_comb begin
        case (quad_reg)
            QUAD_EAST: begin
                cos_pre = c_ext;
                sin_pre = s_ext;
            end
            QUAD_NORTH: begin
                cos_pre = -s_ext;
                sin_pre = c_ext;
            end
            QUAD_WEST: begin
                cos_pre = -c_ext;
                sin_pre = -s_ext;
            end
            QUAD_SOUTH: begin
                cos_pre = s_ext;
                sin_pre = -c_ext;
            end
            default: begin
                cos_pre = c_ext;
                sin_pre = s_ext;
            end
        endcase
        trig_next.cos_q = sat_trig(cos_pre);
        trig_next.sin_q = sat_trig(sin_pre);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            round_reg   <= 1'b0;
            done_reg    <= 1'b0;
            k_reg       <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                running_reg <= 1'b1;
                round_reg   <= 1'b0;
                k_reg       <= '0;
            end else if (running_reg) begin
                k_reg <= k_reg + 1'b1;
                if (k_reg == K_W'(ITERATIONS - 1)) begin
                    running_reg <= 1'b0;
                    round_reg   <= 1'b1;
                end
            end else if (round_reg) begin
                round_reg <= 1'b0;
                done_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= XY_W'(CORDIC_GAIN_Q30);
            y_reg    <= '0;
            z_reg    <= Z_W'(signed'(rem_in));
            quad_reg <= quad_in;
        end else if (running_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (round_reg) begin
            trig_reg <= trig_next;
        end
    end

    assign done = done_reg;
    assign trig = trig_reg;

endmodule

>>> hw/rtl/circle_triangle_fan_generator.sv
// The CORDIC rotator and the multiplier are shared by all rim points of a circle, one point at a time;
// a new circle is accepted only once the last triangle of the previous one is loaded.
// Requests giving no triangles are dropped on acceptance and leave the input ready.
// Reset: aresetn synchronous, active low; clears the sequencer and the output valid.
module circle_triangle_fan_generator #(
    parameter int MAX_SEGMENTS      = 64,
    parameter int COORD_WIDTH       = 24,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // center_x, center_y, radius, segments
    input  logic [((3*COORD_WIDTH+8+7)/8)*8-1:0]        s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // hub_x, hub_y, rim_start_x, rim_start_y, rim_end_x, rim_end_y, segment_index
    output logic [((6*COORD_WIDTH+ctfg_pkg::SEG_IDX_W+7)/8)*8-1:0] m_tdata,
    output logic                                        m_tlast
);
    import ctfg_pkg::*;

    localparam int CW       = COORD_WIDTH;
    localparam int PROD_W   = CW + TRIG_W;
    localparam int OUT_BITS = 6 * CW + SEG_IDX_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int DCNT_W   = 6;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DIV      = 3'd1;
    localparam logic [2:0] S_ROT_INIT = 3'd2;
    localparam logic [2:0] S_ROT      = 3'd3;
    localparam logic [2:0] S_MUL_X    = 3'd4;
    localparam logic [2:0] S_MUL_Y    = 3'd5;
    localparam logic [2:0] S_ADD_Y    = 3'd6;
    localparam logic [2:0] S_NEXT     = 3'd7;

    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    logic [DCNT_W-1:0]        div_cnt_reg;
    logic [SEG_CNT_W-1:0]     pt_cnt_reg;
    logic [SEG_CNT_W-1:0]     n_reg;
    logic [SEG_CNT_W-1:0]     rem_reg;
    logic [ANGLE_W-1:0]       quo_reg;
    logic [ANGLE_W-1:0]       phase_reg;
    logic [SEG_CNT_W-1:0]     frac_reg;
    logic                     out_valid_reg;
    logic                     out_last_reg;
    logic [OUT_BITS-1:0]      out_payload_reg;

    logic signed [CW-1:0]     cx_reg;
    logic signed [CW-1:0]     cy_reg;
    logic signed [CW-1:0]     radius_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [CW-1:0]     new_x_reg;
    logic signed [CW-1:0]     new_y_reg;
    logic signed [CW-1:0]     start_x_reg;
    logic signed [CW-1:0]     start_y_reg;

    logic                     in_xfer;
    logic [7:0]               seg_in;
    logic signed [CW-1:0]     radius_in;
    logic [SEG_CNT_W-1:0]     n_clamp;
    logic                     req_ok;
    logic [SEG_CNT_W-1:0]     div_shift;
    logic                     div_ge;
    logic                     div_last;
    logic [SEG_CNT_W-1:0]     frac_sum;
    logic                     frac_wrap;
    logic [SEG_CNT_W-1:0]     frac_next;
    logic [ANGLE_W-1:0]       phase_next;
    logic                     out_free;
    logic                     out_load;
    logic                     last_pt;
    logic                     first_pt;
    logic [SEG_IDX_W-1:0]     seg_idx;
    logic signed [TRIG_W-1:0] trig_sel;
    logic signed [PROD_W-1:0] prod_next;
    logic                     cordic_start;
    logic                     cordic_done;
    trig_t                    cordic_trig;

    function automatic logic signed [CW-1:0] rim_coord(input logic signed [CW-1:0] c,
                                                       input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] pr;
        logic signed [CW:0]       off;
        logic signed [CW+1:0]     sum;
        logic                     hi_same;
        pr      = p + PROD_W'(16384);
        off     = pr[PROD_W-1:15];
        sum     = (CW+2)'(c) + (CW+2)'(off);
        hi_same = (sum[CW+1:CW-1] == '0) || (sum[CW+1:CW-1] == '1);
        if (hi_same) begin
            return sum[CW-1:0];
        end else if (sum[CW+1]) begin
            return {1'b1, {(CW-1){1'b0}}};
        end else begin
            return {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    ctfg_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .phase   (phase_reg),
        .done    (cordic_done),
        .trig    (cordic_trig)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign seg_in    = s_tdata[3*CW+7:3*CW];
    assign radius_in = s_tdata[3*CW-1:2*CW];
    assign n_clamp   = (seg_in > 8'(MAX_SEGMENTS)) ? SEG_CNT_W'(MAX_SEGMENTS)
                                                   : SEG_CNT_W'(seg_in);
    assign req_ok    = (n_clamp >= SEG_CNT_W'(MIN_SEGMENTS)) && !radius_in[CW-1]
                       && (radius_in != '0);

    // restoring division of 2^32 by n, one quotient bit per cycle
    assign div_shift = {rem_reg[SEG_CNT_W-2:0], (div_cnt_reg == '0)};
    assign div_ge    = (div_shift >= n_reg);
    assign div_last  = (div_cnt_reg == DCNT_W'(ANGLE_W));

    // phase(i+1) = phase(i) + floor(2^32/n), plus one when the remainder accumulates to n or past it
    assign frac_sum   = frac_reg + rem_reg;
    assign frac_wrap  = (frac_sum >= n_reg);
    assign frac_next  = frac_wrap ? (frac_sum - n_reg) : frac_sum;
    assign phase_next = phase_reg + quo_reg + ANGLE_W'(frac_wrap);

    assign out_free     = !out_valid_reg || m_tready;
    assign first_pt     = (pt_cnt_reg == '0);
    assign last_pt      = (pt_cnt_reg == n_reg);
    assign out_load     = (state_reg == S_NEXT) && !first_pt && out_free;
    assign seg_idx      = SEG_IDX_W'(pt_cnt_reg - 1'b1);
    assign cordic_start = (state_reg == S_ROT_INIT);

    assign trig_sel  = (state_reg == S_MUL_X) ? cordic_trig.cos_q : cordic_trig.sin_q;
    assign prod_next = PROD_W'(radius_reg) * PROD_W'(trig_sel);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_xfer && req_ok) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_last) begin
                    state_next = S_ROT_INIT;
                end
            end
            S_ROT_INIT: state_next = S_ROT;
            S_ROT: begin
                if (cordic_done) begin
                    state_next = S_MUL_X;
                end
            end
            S_MUL_X: state_next = S_MUL_Y;
            S_MUL_Y: state_next = S_ADD_Y;
            S_ADD_Y: state_next = S_NEXT;
            S_NEXT: begin
                if (first_pt) begin
                    state_next = S_ROT_INIT;
                end else if (out_free) begin
                    state_next = last_pt ? S_IDLE : S_ROT_INIT;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
            pt_cnt_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (in_xfer) begin
                div_cnt_reg <= '0;
                pt_cnt_reg  <= '0;
            end else if (state_reg == S_DIV) begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end else if ((state_reg == S_NEXT) && (first_pt || out_free)) begin
                pt_cnt_reg <= pt_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cx_reg     <= s_tdata[CW-1:0];
            cy_reg     <= s_tdata[2*CW-1:CW];
            radius_reg <= radius_in;
            n_reg      <= n_clamp;
            rem_reg    <= '0;
        end
        case (state_reg)
            S_DIV: begin
                rem_reg <= div_ge ? (div_shift - n_reg) : div_shift;
                quo_reg <= {quo_reg[ANGLE_W-2:0], div_ge};
                if (div_last) begin
                    phase_reg <= '0;
                    frac_reg  <= '0;
                end
            end
            S_MUL_X: begin
                prod_reg <= prod_next;
            end
            S_MUL_Y: begin
                prod_reg  <= prod_next;
                new_x_reg <= rim_coord(cx_reg, prod_reg);
            end
            S_ADD_Y: begin
                new_y_reg <= rim_coord(cy_reg, prod_reg);
            end
            S_NEXT: begin
                if (first_pt || out_free) begin
                    start_x_reg <= new_x_reg;
                    start_y_reg <= new_y_reg;
                    phase_reg   <= phase_next;
                    frac_reg    <= frac_next;
                end
                if (out_load) begin
                    out_payload_reg <= {seg_idx, new_y_reg, new_x_reg,
                                        start_y_reg, start_x_reg, cy_reg, cx_reg};
                    out_last_reg    <= last_pt;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_payload_reg);
    assign m_tlast  = out_last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (pt_cnt_reg <= n_reg))
        else $error("point counter ran past segment count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_done |-> (state_reg == S_ROT))
        else $error("CORDIC finished outside rotate wait");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_NEXT) && !first_pt && last_pt && out_free)
        |=> ((state_reg == S_IDLE) && m_tvalid && m_tlast))
        else $error("closing triangle not flagged as last");

endmodule

>>> sim/tb_circle_triangle_fan_generator.sv
module tb_circle_triangle_fan_generator;

    import ctfg_pkg::*;

    localparam int MAX_SEGS     = 64;
    localparam int CW           = 24;
    localparam int CORDIC_STEPS = 16;
    localparam int FAN_TARGET   = 180;
    localparam int HOLD_CYCLES  = 3000;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 100;

    localparam longint COORD_MAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint COORD_MIN = -(64'sd1 <<< (CW - 1));
    localparam longint GAIN_Q30  = 64'sd652032874;

    // center_x lowest
    typedef struct packed {
        logic [7:0]           segments;
        logic signed [CW-1:0] radius;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] center_x;
    } circle_req_t;

    // hub_x lowest, final flag on top
    typedef struct packed {
        logic                 last;
        logic [1:0]           pad;
        logic [5:0]           seg_idx;
        logic signed [CW-1:0] end_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] hub_y;
        logic signed [CW-1:0] hub_x;
    } fan_tri_t;

    class fan_scoreboard;
        fan_tri_t pending_tris[$];
        int       fails;
        int       reported;
        longint   arctan_turns[24];

        function new();
            arctan_turns = '{
                536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                10679838, 5340245, 2670163, 1335087, 667544, 333772,
                166886, 83443, 41722, 20861, 10430, 5215,
                2608, 1304, 652, 326, 163, 81};
            fails = 0;
            reported = 0;
        endfunction

        function void unit_vec(input logic [31:0] phase, output longint c,
                               output longint s);
            logic [1:0]  quad;
            logic [31:0] rem;
            longint      z, x, y, dx, dy, cr, sr;
            quad = 2'((phase + 32'h2000_0000) >> 30);
            rem  = phase - {quad, 30'b0};
            z    = longint'($signed(rem));
            x    = GAIN_Q30;
            y    = 0;
            for (int k = 0; k < CORDIC_STEPS && k < 24; k++) begin
                dx = y >>> k;
                dy = x >>> k;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - arctan_turns[k];
                end else begin
                    x = x + dx; y = y - dy; z = z + arctan_turns[k];
                end
            end
            cr = (x + 16384) >>> 15;
            sr = (y + 16384) >>> 15;
            case (quad)
                2'd0: begin c = cr;  s = sr;  end
                2'd1: begin c = -sr; s = cr;  end
                2'd2: begin c = -cr; s = -sr; end
                default: begin c = sr; s = -cr; end
            endcase
            c = c > 32767 ? 32767 : (c < -32768 ? -32768 : c);
            s = s > 32767 ? 32767 : (s < -32768 ? -32768 : s);
        endfunction

        function logic signed [CW-1:0] rim_point(input longint ctr, input longint rad,
                                                 input longint trig);
            longint sum;
            sum = ctr + ((rad * trig + 16384) >>> 15);
            sum = sum > COORD_MAX ? COORD_MAX : (sum < COORD_MIN ? COORD_MIN : sum);
            return sum[CW-1:0];
        endfunction

        // returns the number of triangles queued for this request
        function int note_request(input circle_req_t req);
            longint      cx, cy, rad, c0, s0, c1, s1;
            int          n;
            logic [31:0] ph0, ph1;
            fan_tri_t    t;
            cx  = longint'(req.center_x);
            cy  = longint'(req.center_y);
            rad = longint'(req.radius);
            n   = req.segments > MAX_SEGS ? MAX_SEGS : int'(req.segments);
            if (n < 3 || rad <= 0)
                return 0;
            for (int i = 0; i < n; i++) begin
                ph0 = 32'((64'(i) << 32) / 64'(n));
                ph1 = 32'((64'(i + 1) << 32) / 64'(n));
                unit_vec(ph0, c0, s0);
                unit_vec(ph1, c1, s1);
                t.hub_x   = req.center_x;
                t.hub_y   = req.center_y;
                t.start_x = rim_point(cx, rad, c0);
                t.start_y = rim_point(cy, rad, s0);
                t.end_x   = rim_point(cx, rad, c1);
                t.end_y   = rim_point(cy, rad, s1);
                t.seg_idx = 6'(i);
                t.pad     = '0;
                t.last    = (i + 1 == n);
                pending_tris.push_back(t);
            end
            return n;
        endfunction

        function void check_triangle(input fan_tri_t got);
            fan_tri_t want;
            if (pending_tris.size() == 0) begin
                fails++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected triangle idx %0d hub (%0d,%0d)",
                             got.seg_idx, got.hub_x, got.hub_y);
                end
                return;
            end
            want = pending_tris.pop_front();
            if (got.hub_x != want.hub_x || got.hub_y != want.hub_y ||
                got.start_x != want.start_x || got.start_y != want.start_y ||
                got.end_x != want.end_x || got.end_y != want.end_y ||
                got.seg_idx != want.seg_idx || got.pad != want.pad ||
                got.last != want.last) begin
                fails++;
                if (reported < 10) begin
                    reported++;
                    $display("triangle mismatch");
                    $display("exp hub %0d,%0d start %0d,%0d end %0d,%0d idx %0d pad %0d last %0b",
                             want.hub_x, want.hub_y, want.start_x, want.start_y,
                             want.end_x, want.end_y, want.seg_idx, want.pad, want.last);
                    $display("got hub %0d,%0d start %0d,%0d end %0d,%0d idx %0d pad %0d last %0b",
                             got.hub_x, got.hub_y, got.start_x, got.start_y,
                             got.end_x, got.end_y, got.seg_idx, got.pad, got.last);
                end
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;
    logic         m_tlast;

    fan_scoreboard sb = new();

    int src_idle_pct = 35;
    int snk_idle_pct = 65;
    bit hold_now     = 1'b0;
    int stall_cycles = 0;

    circle_triangle_fan_generator #(
        .MAX_SEGMENTS      (MAX_SEGS),
        .COORD_WIDTH       (CW),
        .CORDIC_ITERATIONS (CORDIC_STEPS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result monitor and stall watchdog
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_triangle({m_tlast, m_tdata});
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random back-pressure, one long hold-off on request
    initial begin
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_now && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    task automatic send_circle(input circle_req_t req, output int tris);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge aclk); while (!s_tready);
        tris = sb.note_request(req);
    endtask

    function automatic circle_req_t random_circle(input bit wants_fan);
        circle_req_t req;
        int          pick;
        req.center_x = CW'($urandom);
        req.center_y = CW'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50)
            req.radius = CW'($urandom_range(1, 8388607));
        else if (pick < 75)
            req.radius = CW'($urandom_range(1, 65535));
        else
            req.radius = CW'($urandom_range(4194304, 8388607));
        pick = $urandom_range(0, 99);
        if (pick < 70)
            req.segments = 8'($urandom_range(3, 16));
        else if (pick < 93)
            req.segments = 8'($urandom_range(17, 64));
        else
            req.segments = 8'($urandom_range(65, 255));
        if (!wants_fan) begin
            if ($urandom_range(0, 1))
                req.segments = 8'($urandom_range(0, 2));
            else
                req.radius = -CW'($urandom_range(0, 8388608));
        end
        return req;
    endfunction

    initial begin
        circle_req_t directed[$];
        circle_req_t req;
        int          fans;
        int          tris;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // too few segments, non-positive radius, clamping, saturation at both rails
        directed.push_back('{8'd0,   24'sd1000,     24'sd0,        24'sd0});
        directed.push_back('{8'd1,   24'sd1000,     24'sd0,        24'sd0});
        directed.push_back('{8'd2,   24'sd1000,     24'sd0,        24'sd0});
        directed.push_back('{8'd8,   24'sd0,        24'sd0,        24'sd0});
        directed.push_back('{8'd8,   -24'sd8388608, 24'sd5,        24'sd5});
        directed.push_back('{8'd6,   -24'sd1,       24'sd5,        24'sd5});
        directed.push_back('{8'd3,   24'sd1,        24'sd0,        24'sd0});
        directed.push_back('{8'd3,   24'sd256,      24'sd100,      -24'sd100});
        directed.push_back('{8'd4,   24'sd8388607,  24'sd8388607,  24'sd8388607});
        directed.push_back('{8'd64,  24'sd8388607,  -24'sd8388608, -24'sd8388608});
        directed.push_back('{8'd255, 24'sd4096,     24'sd8388607,  -24'sd8388608});
        directed.push_back('{8'd65,  24'sd12345,    -24'sd8388608, 24'sd8388607});
        directed.push_back('{8'd63,  24'sd8388607,  24'sd0,        24'sd0});
        directed.push_back('{8'd5,   24'sd8388607,  24'sd4194304,  -24'sd4194304});
        directed.push_back('{8'd7,   24'sd1,        -24'sd1,       24'sd1});
        directed.push_back('{8'd128, 24'sd300,      24'sd1,        -24'sd1});
        directed.push_back('{8'd16,  24'sd65535,    24'sd0,        24'sd0});

        fans = 0;
        foreach (directed[i]) begin
            send_circle(directed[i], tris);
            if (tris > 0)
                fans++;
        end

        while (fans < FAN_TARGET) begin
            if (fans >= 2 * FAN_TARGET / 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
                hold_now     = 1'b1;
            end else if (fans >= FAN_TARGET / 3) begin
                src_idle_pct = 65;
                snk_idle_pct = 35;
            end
            req = random_circle($urandom_range(0, 99) >= 10);
            send_circle(req, tris);
            if (tris > 0)
                fans++;
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (sb.pending_tris.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.fails == 0 && sb.pending_tris.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
